// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for clocked assertions with a synchronous reset that disables
// them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold in the same cycle as the trigger.
`define ASSERT_NOW(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("assertion violated");

// Condition must hold in the cycle after the trigger.
`define ASSERT_NEXT(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("assertion violated");

`endif

// ===== rtl/bavg_pkg.sv =====
// ----------------------------------------------------------------------------
// bavg_pkg
// Shared types, constants and the reciprocal table of the block averager.
// ----------------------------------------------------------------------------
`default_nettype none

package bavg_pkg;

  // Field widths.
  localparam int PIX_W       = 8;
  localparam int SUM_W       = 12;
  localparam int CFG_W       = 12;
  localparam int CFG_INDEX_W = 8;
  localparam int CNT_W       = 5;
  localparam int RECIP_W     = 18;
  localparam int RECIP_SHIFT = 17;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 8'd1;

  // Pixel count thresholds for the block size choice.
  localparam logic [31:0] SMALL_LIMIT = 32'd90000;
  localparam logic [31:0] LARGE_LIMIT = 32'd800000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cfg_write;
    logic size_mul;
    logic size_set;
    logic accept;
    logic add;
    logic mul;
    logic out_load;
  } bavg_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cfg_index_ok;
    logic block_end;
  } bavg_sts_t;

  // Rounded-up reciprocal ceil(2^17 / count). For sums below 4096 and counts
  // up to 16 the product shifted right by 17 is exactly floor(sum / count).
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] count);
    logic [RECIP_W-1:0] r;
    case (count)
      5'd1:    r = 18'd131072;
      5'd2:    r = 18'd65536;
      5'd3:    r = 18'd43691;
      5'd4:    r = 18'd32768;
      5'd5:    r = 18'd26215;
      5'd6:    r = 18'd21846;
      5'd7:    r = 18'd18725;
      5'd8:    r = 18'd16384;
      5'd9:    r = 18'd14564;
      5'd10:   r = 18'd13108;
      5'd11:   r = 18'd11916;
      5'd12:   r = 18'd10923;
      5'd13:   r = 18'd10083;
      5'd14:   r = 18'd9363;
      5'd15:   r = 18'd8739;
      5'd16:   r = 18'd8192;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bavg_ctrl.sv =====
// ----------------------------------------------------------------------------
// bavg_ctrl
// Controller: sequences configuration, accumulation, division and output.
// ----------------------------------------------------------------------------
`default_nettype none

module bavg_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               in_valid,
  output logic                    in_stall,
  output logic                    out_valid,
  input  wire logic               out_stall,
  input  wire bavg_pkg::bavg_sts_t sts,
  output bavg_pkg::bavg_cmd_t     cmd
);
  import bavg_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_ADD      = 3'd1;
  localparam logic [2:0] S_MUL      = 3'd2;
  localparam logic [2:0] S_OUT      = 3'd3;
  localparam logic [2:0] S_SIZE_MUL = 3'd4;
  localparam logic [2:0] S_SIZE_SET = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid_next;
  logic       out_free;

  // Configuration writes are always taken. A pixel is held off while a
  // register write is on the port, so the two never share an edge.
  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE) || cfg_valid;
  assign out_free  = !out_valid || !out_stall;

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.cfg_write = cfg_valid;
    case (state)
      S_IDLE: begin
        if (in_valid && !cfg_valid) begin
          cmd.accept = 1'b1;
          state_next = S_ADD;
        end
      end
      S_ADD: begin
        cmd.add    = 1'b1;
        state_next = sts.block_end ? S_MUL : S_IDLE;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_SIZE_MUL: begin
        cmd.size_mul = 1'b1;
        state_next   = S_SIZE_SET;
      end
      S_SIZE_SET: begin
        cmd.size_set = 1'b1;
        state_next   = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    // A register write restarts the frame and recomputes the block size.
    if (cfg_valid && sts.cfg_index_ok) begin
      state_next = S_SIZE_MUL;
    end
  end

  // Output beat valid flag.
  always_comb begin
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_stall) begin
      out_valid_next = out_valid;
    end else begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bavg_dp.sv =====
// ----------------------------------------------------------------------------
// bavg_dp
// Datapath: size registers, position counters, column sum memory and the
// reciprocal divider.
// ----------------------------------------------------------------------------
`default_nettype none

module bavg_dp #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048,
  parameter int MAX_BLOCK  = 3
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic [bavg_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [bavg_pkg::CFG_W-1:0]          cfg_data,
  input  wire logic [bavg_pkg::PIX_W-1:0]          channel_0,
  input  wire logic [bavg_pkg::PIX_W-1:0]          channel_1,
  input  wire logic [bavg_pkg::PIX_W-1:0]          channel_2,
  output logic [bavg_pkg::PIX_W-1:0]               avg_channel_0,
  output logic [bavg_pkg::PIX_W-1:0]               avg_channel_1,
  output logic [bavg_pkg::PIX_W-1:0]               avg_channel_2,
  output logic                                     frame_end,
  input  wire bavg_pkg::bavg_cmd_t                 cmd,
  output bavg_pkg::bavg_sts_t                      sts
);
  import bavg_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int CW = WW + 1;
  localparam int RW = HW + 1;
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int BW = $clog2(MAX_BLOCK + 1);
  localparam int PW = WW + HW;
  localparam int MW = SUM_W + RECIP_W;

  // Configuration and block size.
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  logic [WW-1:0]    dim_w;
  logic [HW-1:0]    dim_h;
  logic [PW-1:0]    total_prod;
  logic [BW-1:0]    cur_block;
  logic [BW-1:0]    block_rule;

  // Position in the frame.
  logic [AW-1:0]    pixel_column;
  logic [YW-1:0]    pixel_row;
  logic [AW-1:0]    block_column;
  logic [BW-1:0]    column_phase;
  logic [BW-1:0]    row_phase;
  logic             col_last;
  logic             row_last;
  logic             col_wrap;
  logic             row_wrap;
  logic             first_pixel;

  // Accumulation and division.
  logic [PIX_W-1:0]     pix      [3];
  logic [PIX_W-1:0]     pix_reg  [3];
  logic [3*SUM_W-1:0]   mem      [MAX_WIDTH];
  logic [3*SUM_W-1:0]   rd_data;
  logic [SUM_W-1:0]     sum      [3];
  logic [3*SUM_W-1:0]   sum_word;
  logic [SUM_W-1:0]     sum_reg  [3];
  logic [2*BW-1:0]      count;
  logic [CNT_W-1:0]     count_reg;
  logic                 last_reg;
  logic                 last_prod;
  logic [MW-1:0]        prod     [3];

  assign pix[0] = channel_0;
  assign pix[1] = channel_1;
  assign pix[2] = channel_2;

  assign sts.cfg_index_ok = (cfg_index == REG_IMAGE_WIDTH) ||
                            (cfg_index == REG_IMAGE_HEIGHT);

  // Clamp the programmed size to the supported range.
  always_comb begin
    if (width_reg == '0) begin
      dim_w = WW'(1);
    end else if (32'(width_reg) > MAX_WIDTH) begin
      dim_w = WW'(MAX_WIDTH);
    end else begin
      dim_w = WW'(width_reg);
    end
    if (height_reg == '0) begin
      dim_h = HW'(1);
    end else if (32'(height_reg) > MAX_HEIGHT) begin
      dim_h = HW'(MAX_HEIGHT);
    end else begin
      dim_h = HW'(height_reg);
    end
  end

  // Block size from the pixel count, capped by the largest supported block.
  always_comb begin
    if (32'(total_prod) < SMALL_LIMIT) begin
      block_rule = BW'(1);
    end else if (32'(total_prod) < LARGE_LIMIT || MAX_BLOCK < 3) begin
      block_rule = (MAX_BLOCK < 2) ? BW'(1) : BW'(2);
    end else begin
      block_rule = BW'(3);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= CFG_W'(1);
      height_reg <= CFG_W'(1);
      cur_block  <= BW'(1);
    end else begin
      if (cmd.cfg_write && cfg_index == REG_IMAGE_WIDTH) begin
        width_reg <= cfg_data;
      end
      if (cmd.cfg_write && cfg_index == REG_IMAGE_HEIGHT) begin
        height_reg <= cfg_data;
      end
      if (cmd.size_set) begin
        cur_block <= block_rule;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.size_mul) begin
      total_prod <= PW'(dim_w) * PW'(dim_h);
    end
  end

  // Edge and block boundary flags for the current pixel.
  assign col_last    = (CW'(pixel_column) + CW'(1)) >= CW'(dim_w);
  assign row_last    = (RW'(pixel_row) + RW'(1)) >= RW'(dim_h);
  assign col_wrap    = (column_phase + BW'(1)) >= cur_block;
  assign row_wrap    = (row_phase + BW'(1)) >= cur_block;
  assign first_pixel = (column_phase == '0) && (row_phase == '0);
  assign sts.block_end = (col_last || col_wrap) && (row_last || row_wrap);
  assign count = (2*BW)'(column_phase + BW'(1)) * (2*BW)'(row_phase + BW'(1));

  // Raster position counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_column <= '0;
      pixel_row    <= '0;
      block_column <= '0;
      column_phase <= '0;
      row_phase    <= '0;
    end else if (cmd.cfg_write && sts.cfg_index_ok) begin
      pixel_column <= '0;
      pixel_row    <= '0;
      block_column <= '0;
      column_phase <= '0;
      row_phase    <= '0;
    end else if (cmd.add) begin
      if (col_last) begin
        pixel_column <= '0;
        block_column <= '0;
        column_phase <= '0;
        if (row_last) begin
          pixel_row <= '0;
          row_phase <= '0;
        end else begin
          pixel_row <= pixel_row + YW'(1);
          row_phase <= row_wrap ? '0 : row_phase + BW'(1);
        end
      end else begin
        pixel_column <= pixel_column + AW'(1);
        if (col_wrap) begin
          column_phase <= '0;
          block_column <= block_column + AW'(1);
        end else begin
          column_phase <= column_phase + BW'(1);
        end
      end
    end
  end

  // New running sums; the first pixel of a block starts from zero.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum[c] = (first_pixel ? SUM_W'(0) : rd_data[c*SUM_W +: SUM_W]) + SUM_W'(pix_reg[c]);
    end
    sum_word = {sum[2], sum[1], sum[0]};
  end

  // Column sum memory: read on accept, written back in the add cycle.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_data <= mem[block_column];
    end
    if (cmd.add) begin
      mem[block_column] <= sum_word;
    end
  end

  // Pixel latch, sum register, reciprocal multiply and output register.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pix_reg <= pix;
    end
    if (cmd.add) begin
      sum_reg   <= sum;
      count_reg <= CNT_W'(count);
      last_reg  <= col_last && row_last;
    end
    if (cmd.mul) begin
      for (int c = 0; c < 3; c++) begin
        prod[c] <= MW'(sum_reg[c]) * MW'(recip(count_reg));
      end
      last_prod <= last_reg;
    end
    if (cmd.out_load) begin
      avg_channel_0 <= prod[0][RECIP_SHIFT +: PIX_W];
      avg_channel_1 <= prod[1][RECIP_SHIFT +: PIX_W];
      avg_channel_2 <= prod[2][RECIP_SHIFT +: PIX_W];
      frame_end     <= last_prod;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/block_average_downsampler.sv =====
// ----------------------------------------------------------------------------
// block_average_downsampler
// Averages square blocks of three-channel pixels into one pixel per block.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake            Beat contents
//   -------   ------------------   ------------------------------------------
//   cfg       cfg_valid/cfg_ready  cfg_index, cfg_data (width or height)
//   in        in_valid/in_stall    channel_0, channel_1, channel_2
//   out       out_valid/out_stall  avg_channel_0..2, frame_end
//
// A pixel that does not close a block is handled as a column sum memory
// read, then the add and write back. A pixel that closes a block goes on
// to the reciprocal multiply, then the load into the output register,
// which waits while a previous result is still stalled. A register write
// recomputes the block size with a size multiply, then a size set.
// Reset is synchronous; the column sum memory is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module block_average_downsampler #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048,
  parameter int MAX_BLOCK  = 3
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [bavg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [bavg_pkg::CFG_W-1:0]       cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [bavg_pkg::PIX_W-1:0]       channel_0,
  input  wire logic [bavg_pkg::PIX_W-1:0]       channel_1,
  input  wire logic [bavg_pkg::PIX_W-1:0]       channel_2,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [bavg_pkg::PIX_W-1:0]            avg_channel_0,
  output logic [bavg_pkg::PIX_W-1:0]            avg_channel_1,
  output logic [bavg_pkg::PIX_W-1:0]            avg_channel_2,
  output logic                                  frame_end
);
  import bavg_pkg::*;

  bavg_cmd_t cmd;
  bavg_sts_t sts;

  // Sequencing.
  bavg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Accumulation and averaging.
  bavg_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_BLOCK  (MAX_BLOCK)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .channel_0     (channel_0),
    .channel_1     (channel_1),
    .channel_2     (channel_2),
    .avg_channel_0 (avg_channel_0),
    .avg_channel_1 (avg_channel_1),
    .avg_channel_2 (avg_channel_2),
    .frame_end     (frame_end),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule

`default_nettype wire

// ===== rtl/bavg_checker.sv =====
// ----------------------------------------------------------------------------
// bavg_checker
// Port level checks of the block averager, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bavg_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             cfg_valid,
  input wire logic                             cfg_ready,
  input wire logic [bavg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input wire logic                             in_valid,
  input wire logic                             in_stall,
  input wire logic                             out_valid,
  input wire logic                             out_stall,
  input wire logic [bavg_pkg::PIX_W-1:0]       avg_channel_0,
  input wire logic [bavg_pkg::PIX_W-1:0]       avg_channel_1,
  input wire logic [bavg_pkg::PIX_W-1:0]       avg_channel_2,
  input wire logic                             frame_end
);
  import bavg_pkg::*;

  logic             in_beat;
  logic             size_write;
  logic [3*PIX_W:0] out_word;

  assign in_beat    = in_valid && !in_stall;
  assign size_write = cfg_valid && cfg_ready &&
                      (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);
  assign out_word   = {avg_channel_0, avg_channel_1, avg_channel_2, frame_end};

  // A stalled result keeps its valid and its payload.
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_word))

  // One pixel at a time: the input is stalled right after a beat.
  `ASSERT_NEXT(a_one_in_flight, clk, rst, in_beat, in_stall)

  // A size write holds off pixels while the block size is recomputed.
  `ASSERT_NEXT(a_size_recompute, clk, rst, size_write, in_stall)

  // No result can appear in the cycle after a pixel beat.
  `ASSERT_NOW(a_no_early_result, clk, rst, in_beat, ##1 !$rose(out_valid))

endmodule

bind block_average_downsampler bavg_checker u_bavg_checker (.*);

`default_nettype wire
